// ===== hw/rtl/pga_pkg.sv =====
// shared types and constants for the pairwise gravity acceleration pipeline
package pga_pkg;

    // field widths
    localparam int POS_W   = 32;
    localparam int MASS_W  = 32;
    localparam int GAIN_W  = 32;
    localparam int ACC_W   = 32;

    // gain register reset value, 1.0 in unsigned Q8.24
    localparam logic [GAIN_W-1:0] GAIN_RESET = 32'd16777216;
    // fraction bits of the gain
    localparam int GAIN_FRAC = 24;

    // internal arithmetic widths
    localparam int DIFF_W  = POS_W + 1;            // full-width difference
    localparam int UMAG_W  = POS_W - 1;            // magnitude after range shift
    localparam int SQ_W    = 2 * UMAG_W + 1;       // sum of two squares
    localparam int ROOT_W  = 32;                   // isqrt result
    localparam int GM_W    = GAIN_W + MASS_W;      // gain times mass
    localparam int NUM_W   = GM_W + UMAG_W;        // gain * mass * magnitude
    localparam int CUBE_W  = 95;                   // root cubed, root < 2^31.5
    localparam int QUO_W   = ACC_W - 1;            // quotient bits below the saturation point

    localparam logic signed [ACC_W-1:0] ACC_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [ACC_W-1:0] ACC_MIN = 32'sh8000_0000;

    // input beat
    typedef struct packed {
        logic signed [POS_W-1:0]  self_x;
        logic signed [POS_W-1:0]  self_y;
        logic signed [POS_W-1:0]  other_x;
        logic signed [POS_W-1:0]  other_y;
        logic        [MASS_W-1:0] self_mass;
        logic        [MASS_W-1:0] other_mass;
    } pga_in_t;

    // output beat
    typedef struct packed {
        logic signed [ACC_W-1:0] self_ax;
        logic signed [ACC_W-1:0] self_ay;
        logic signed [ACC_W-1:0] other_ax;
        logic signed [ACC_W-1:0] other_ay;
        logic                    applied;
    } pga_out_t;

    // data that rides alongside the square root
    typedef struct packed {
        logic [GM_W-1:0]   go;
        logic [GM_W-1:0]   gs;
        logic [UMAG_W-1:0] ux;
        logic [UMAG_W-1:0] uy;
        logic              neg_x;
        logic              neg_y;
        logic              shift;
        logic              close;
    } pga_side_t;

    // divider operands, lane order: self x, self y, other x, other y
    typedef struct packed {
        logic [3:0][NUM_W-1:0] num;
        logic [CUBE_W-1:0]     cube;
        logic                  neg_x;
        logic                  neg_y;
        logic                  shift;
        logic                  close;
    } pga_ops_t;

endpackage

// ===== hw/rtl/pairwise_gravity_accel_top.sv =====
// top level of the pairwise gravity acceleration pipeline
//
//  channel   direction  signals                      beat
//  in        sink       in_valid in_ready in_data    two positions and two masses
//  out       source     out_valid out_ready out_data four increments and applied flag
//  cfg       sink       cfg_we cfg_wdata             gravity gain, Q8.24
//
// one beat enters per cycle while the output register is not stalled; each beat passes
// through the front, square root, multiply, divide and output register stages in turn.
// reset clears all valid bits and loads the gain with 1.0.
// when the output register holds a beat that is not taken, the whole pipeline
// holds and in_ready drops; no beat is lost or repeated.
module pairwise_gravity_accel_top
    import pga_pkg::*;
#(
    parameter int FRAC_BITS = 16
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  pga_in_t           in_data,
    output logic              out_valid,
    input  logic              out_ready,
    output pga_out_t          out_data,
    input  logic              cfg_we,
    input  logic [GAIN_W-1:0] cfg_wdata
);

    // scale exponent: num * 2^E0 / (cube * 4^shift)
    localparam int E0   = 2 * FRAC_BITS - GAIN_FRAC;
    localparam int EPOS = (E0 > 0) ? E0 : 0;
    localparam int ENEG = (E0 < 0) ? -E0 : 0;
    localparam int DN_W = NUM_W + EPOS;
    localparam int DD_W = CUBE_W + ENEG + 2;

    logic              en;
    logic [GAIN_W-1:0] gain_reg;

    logic              fr_valid;
    logic [SQ_W-1:0]   fr_sq;
    pga_side_t         fr_side;

    logic              sq_valid;
    logic [ROOT_W-1:0] sq_root;
    logic [$bits(pga_side_t)-1:0] sq_side;

    logic              pr_valid;
    pga_ops_t          pr_ops;
    logic [DD_W-1:0]   den;

    logic [3:0]              dv_valid;
    logic [3:0][QUO_W-1:0]   dv_quo;
    logic [3:0]              dv_ovf;
    logic [3:0][1:0]         dv_side;

    logic              out_valid_reg;
    pga_out_t          out_data_reg;
    pga_out_t          out_next;

    // sign and saturation of one component
    function automatic logic signed [ACC_W-1:0] sat_acc(
        input logic [QUO_W-1:0] q,
        input logic             ovf,
        input logic             neg
    );
        logic signed [ACC_W-1:0] mag;
        mag = {1'b0, q};
        if (ovf)
            return neg ? ACC_MIN : ACC_MAX;
        else
            return neg ? -mag : mag;
    endfunction

    // global advance: the output register is free or being drained
    assign en       = !out_valid_reg || out_ready;
    assign in_ready = en;

    // gain register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            gain_reg <= GAIN_RESET;
        else if (cfg_we)
            gain_reg <= cfg_wdata;
    end

    pga_front #(
        .FRAC_BITS (FRAC_BITS)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .gain      (gain_reg),
        .in_valid  (in_valid),
        .in_data   (in_data),
        .out_valid (fr_valid),
        .out_sq    (fr_sq),
        .out_side  (fr_side)
    );

    pga_sqrt #(
        .R_W    (ROOT_W),
        .SIDE_W ($bits(pga_side_t))
    ) u_sqrt (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (fr_valid),
        .in_val    ((2*ROOT_W)'(fr_sq)),
        .in_side   (fr_side),
        .out_valid (sq_valid),
        .out_root  (sq_root),
        .out_side  (sq_side)
    );

    pga_prep u_prep (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (sq_valid),
        .in_root   (sq_root),
        .in_side   (pga_side_t'(sq_side)),
        .out_valid (pr_valid),
        .out_ops   (pr_ops)
    );

    // divisor scaled by the exponent and the range shift
    assign den = (DD_W'(pr_ops.cube) << ENEG) << (pr_ops.shift ? 2 : 0);

    // four divider lanes: self x, self y, other x, other y
    for (genvar i = 0; i < 4; i++)
    begin : g_lane
        logic neg;
        assign neg = (i % 2 == 0) ? pr_ops.neg_x : pr_ops.neg_y;

        pga_div #(
            .N_W    (DN_W),
            .D_W    (DD_W),
            .SIDE_W (2)
        ) u_div (
            .clk       (clk),
            .rst_n     (rst_n),
            .en        (en),
            .in_valid  (pr_valid),
            .in_num    (DN_W'(pr_ops.num[i]) << EPOS),
            .in_den    (den),
            .in_side   ({pr_ops.close, neg}),
            .out_valid (dv_valid[i]),
            .out_quo   (dv_quo[i]),
            .out_ovf   (dv_ovf[i]),
            .out_side  (dv_side[i])
        );
    end

    // result assembly, too-close pairs give zero
    always_comb
    begin
        out_next.self_ax  = sat_acc(dv_quo[0], dv_ovf[0], dv_side[0][0]);
        out_next.self_ay  = sat_acc(dv_quo[1], dv_ovf[1], dv_side[1][0]);
        out_next.other_ax = sat_acc(dv_quo[2], dv_ovf[2], dv_side[2][0]);
        out_next.other_ay = sat_acc(dv_quo[3], dv_ovf[3], dv_side[3][0]);
        out_next.applied  = 1'b1;
        if (dv_side[0][1])
        begin
            out_next.self_ax  = '0;
            out_next.self_ay  = '0;
            out_next.other_ax = '0;
            out_next.other_ay = '0;
            out_next.applied  = 1'b0;
        end
    end

    // output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (en)
            out_valid_reg <= dv_valid[0] & dv_valid[1] & dv_valid[2] & dv_valid[3];
    end

    always_ff @(posedge clk)
    begin
        if (en)
            out_data_reg <= out_next;
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

endmodule

// ===== hw/rtl/pga_front.sv =====
// front stages: differences, magnitudes, range shift, squares and mass products
module pga_front
    import pga_pkg::*;
#(
    parameter int FRAC_BITS = 16
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              en,
    input  logic [GAIN_W-1:0] gain,
    input  logic              in_valid,
    input  pga_in_t           in_data,
    output logic              out_valid,
    output logic [SQ_W-1:0]   out_sq,
    output pga_side_t         out_side
);

    localparam logic [63:0] CLOSE_LIM = 64'd1 << (2 * FRAC_BITS);

    logic [3:0] v_reg;

    pga_in_t            in1_reg;

    logic [DIFF_W-1:0]  ux2_reg, uy2_reg;
    logic               negx2_reg, negy2_reg;
    logic [GM_W-1:0]    go2_reg, gs2_reg;

    logic [2*UMAG_W-1:0] sqx3_reg, sqy3_reg;
    logic [UMAG_W-1:0]  ux3_reg, uy3_reg;
    logic               s3_reg, negx3_reg, negy3_reg;
    logic [GM_W-1:0]    go3_reg, gs3_reg;

    logic [SQ_W-1:0]    sq4_reg;
    pga_side_t          side4_reg;

    logic [DIFF_W-1:0]  dx_next, dy_next, ux_next, uy_next;
    logic               s_next;
    logic [UMAG_W-1:0]  uxs_next, uys_next;
    logic [SQ_W-1:0]    sq_next;

    // valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v_reg <= '0;
        else if (en)
            v_reg <= {v_reg[2:0], in_valid};
    end

    // signed differences and their magnitudes
    always_comb
    begin
        dx_next = {in1_reg.other_x[POS_W-1], in1_reg.other_x}
                - {in1_reg.self_x[POS_W-1], in1_reg.self_x};
        dy_next = {in1_reg.other_y[POS_W-1], in1_reg.other_y}
                - {in1_reg.self_y[POS_W-1], in1_reg.self_y};
        ux_next = dx_next[DIFF_W-1] ? (~dx_next + 1'b1) : dx_next;
        uy_next = dy_next[DIFF_W-1] ? (~dy_next + 1'b1) : dy_next;
    end

    // range shift keeps both magnitudes below 2^31
    always_comb
    begin
        s_next   = ux2_reg[DIFF_W-1] | ux2_reg[DIFF_W-2] | uy2_reg[DIFF_W-1] | uy2_reg[DIFF_W-2];
        uxs_next = s_next ? ux2_reg[DIFF_W-2:1] : ux2_reg[UMAG_W-1:0];
        uys_next = s_next ? uy2_reg[DIFF_W-2:1] : uy2_reg[UMAG_W-1:0];
        sq_next  = SQ_W'(sqx3_reg) + SQ_W'(sqy3_reg);
    end

    // payload stages
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            in1_reg   <= in_data;

            ux2_reg   <= ux_next;
            uy2_reg   <= uy_next;
            negx2_reg <= dx_next[DIFF_W-1];
            negy2_reg <= dy_next[DIFF_W-1];
            go2_reg   <= GM_W'(gain) * GM_W'(in1_reg.other_mass);
            gs2_reg   <= GM_W'(gain) * GM_W'(in1_reg.self_mass);

            sqx3_reg  <= (2*UMAG_W)'(uxs_next) * (2*UMAG_W)'(uxs_next);
            sqy3_reg  <= (2*UMAG_W)'(uys_next) * (2*UMAG_W)'(uys_next);
            ux3_reg   <= uxs_next;
            uy3_reg   <= uys_next;
            s3_reg    <= s_next;
            negx3_reg <= negx2_reg;
            negy3_reg <= negy2_reg;
            go3_reg   <= go2_reg;
            gs3_reg   <= gs2_reg;

            sq4_reg         <= sq_next;
            side4_reg.go    <= go3_reg;
            side4_reg.gs    <= gs3_reg;
            side4_reg.ux    <= ux3_reg;
            side4_reg.uy    <= uy3_reg;
            side4_reg.neg_x <= negx3_reg;
            side4_reg.neg_y <= negy3_reg;
            side4_reg.shift <= s3_reg;
            side4_reg.close <= !s3_reg && (64'(sq_next) <= CLOSE_LIM);
        end
    end

    assign out_valid = v_reg[3];
    assign out_sq    = sq4_reg;
    assign out_side  = side4_reg;

endmodule

// ===== hw/rtl/pga_sqrt.sv =====
// pipelined integer square root, one result bit per stage
module pga_sqrt
    import pga_pkg::*;
#(
    parameter int R_W    = 32,
    parameter int SIDE_W = 1
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              en,
    input  logic              in_valid,
    input  logic [2*R_W-1:0]  in_val,
    input  logic [SIDE_W-1:0] in_side,
    output logic              out_valid,
    output logic [R_W-1:0]    out_root,
    output logic [SIDE_W-1:0] out_side
);

    localparam int V_W = 2 * R_W;
    localparam int T_W = V_W + 2;

    logic [R_W:0]        v_reg;
    logic [V_W-1:0]      rem_reg  [0:R_W];
    logic [R_W-1:0]      root_reg [0:R_W];
    logic [SIDE_W-1:0]   side_reg [0:R_W];

    // valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v_reg <= '0;
        else if (en)
            v_reg <= {v_reg[R_W-1:0], in_valid};
    end

    // load stage
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rem_reg[0]  <= in_val;
            root_reg[0] <= '0;
            side_reg[0] <= in_side;
        end
    end

    // one root bit per stage, most significant first
    for (genvar k = 1; k <= R_W; k++)
    begin : g_bit
        localparam int B = R_W - k;
        logic [T_W-1:0] trial;
        logic [T_W-1:0] diff;
        logic           take;
        logic [V_W-1:0] rem_next;
        logic [R_W-1:0] root_next;

        always_comb
        begin
            trial     = (T_W'(root_reg[k-1]) << (B + 1)) + (T_W'(1) << (2 * B));
            diff      = T_W'(rem_reg[k-1]) - trial;
            take      = !diff[T_W-1];
            rem_next  = take ? diff[V_W-1:0] : rem_reg[k-1];
            root_next = take ? (root_reg[k-1] | (R_W'(1) << B)) : root_reg[k-1];
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rem_reg[k]  <= rem_next;
                root_reg[k] <= root_next;
                side_reg[k] <= side_reg[k-1];
            end
        end
    end

    assign out_valid = v_reg[R_W];
    assign out_root  = root_reg[R_W];
    assign out_side  = side_reg[R_W];

endmodule

// ===== hw/rtl/pga_prep.sv =====
// divider operand stages: root cubed and the four numerators, split multiplies
module pga_prep
    import pga_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              en,
    input  logic              in_valid,
    input  logic [ROOT_W-1:0] in_root,
    input  pga_side_t         in_side,
    output logic              out_valid,
    output pga_ops_t          out_ops
);

    localparam int PP_W = 32 + UMAG_W;

    logic [2:0]              v_reg;

    logic [ROOT_W-1:0]       r1_reg;
    logic [2*ROOT_W-1:0]     r2_1_reg;
    logic [3:0][PP_W-1:0]    pplo1_reg, pphi1_reg;
    logic                    negx1_reg, negy1_reg, s1_reg, close1_reg;

    logic [2*ROOT_W-1:0]     clo2_reg, chi2_reg;
    logic [3:0][NUM_W-1:0]   num2_reg;
    logic                    negx2_reg, negy2_reg, s2_reg, close2_reg;

    pga_ops_t                ops3_reg;

    logic [3:0][GM_W-1:0]    gm;
    logic [3:0][UMAG_W-1:0]  um;

    // lane operands
    always_comb
    begin
        gm[0] = in_side.go;  um[0] = in_side.ux;
        gm[1] = in_side.go;  um[1] = in_side.uy;
        gm[2] = in_side.gs;  um[2] = in_side.ux;
        gm[3] = in_side.gs;  um[3] = in_side.uy;
    end

    // valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v_reg <= '0;
        else if (en)
            v_reg <= {v_reg[1:0], in_valid};
    end

    // partial products, then sums
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            r1_reg   <= in_root;
            r2_1_reg <= (2*ROOT_W)'(in_root) * (2*ROOT_W)'(in_root);
            for (int i = 0; i < 4; i++)
            begin
                pplo1_reg[i] <= PP_W'(gm[i][31:0]) * PP_W'(um[i]);
                pphi1_reg[i] <= PP_W'(gm[i][GM_W-1:32]) * PP_W'(um[i]);
            end
            negx1_reg  <= in_side.neg_x;
            negy1_reg  <= in_side.neg_y;
            s1_reg     <= in_side.shift;
            close1_reg <= in_side.close;

            clo2_reg <= (2*ROOT_W)'(r2_1_reg[31:0]) * (2*ROOT_W)'(r1_reg);
            chi2_reg <= (2*ROOT_W)'(r2_1_reg[2*ROOT_W-1:32]) * (2*ROOT_W)'(r1_reg);
            for (int i = 0; i < 4; i++)
                num2_reg[i] <= NUM_W'(pplo1_reg[i]) + (NUM_W'(pphi1_reg[i]) << 32);
            negx2_reg  <= negx1_reg;
            negy2_reg  <= negy1_reg;
            s2_reg     <= s1_reg;
            close2_reg <= close1_reg;

            ops3_reg.cube  <= CUBE_W'(clo2_reg) + (CUBE_W'(chi2_reg) << 32);
            ops3_reg.num   <= num2_reg;
            ops3_reg.neg_x <= negx2_reg;
            ops3_reg.neg_y <= negy2_reg;
            ops3_reg.shift <= s2_reg;
            ops3_reg.close <= close2_reg;
        end
    end

    assign out_valid = v_reg[2];
    assign out_ops   = ops3_reg;

endmodule

// ===== hw/rtl/pga_div.sv =====
// pipelined restoring divider, one quotient bit per stage, with overflow flag
module pga_div
    import pga_pkg::*;
#(
    parameter int N_W    = 95,
    parameter int D_W    = 97,
    parameter int SIDE_W = 2
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              en,
    input  logic              in_valid,
    input  logic [N_W-1:0]    in_num,
    input  logic [D_W-1:0]    in_den,
    input  logic [SIDE_W-1:0] in_side,
    output logic              out_valid,
    output logic [QUO_W-1:0]  out_quo,
    output logic              out_ovf,
    output logic [SIDE_W-1:0] out_side
);

    localparam int C_W = ((N_W > D_W + QUO_W) ? N_W : D_W + QUO_W) + 1;

    logic [QUO_W:0]      v_reg;
    logic [N_W-1:0]      rem_reg  [0:QUO_W];
    logic [D_W-1:0]      den_reg  [0:QUO_W];
    logic [QUO_W-1:0]    quo_reg  [0:QUO_W];
    logic                ovf_reg  [0:QUO_W];
    logic [SIDE_W-1:0]   side_reg [0:QUO_W];

    // valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v_reg <= '0;
        else if (en)
            v_reg <= {v_reg[QUO_W-1:0], in_valid};
    end

    // load stage, quotient at or above 2^31 flags overflow
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rem_reg[0]  <= in_num;
            den_reg[0]  <= in_den;
            quo_reg[0]  <= '0;
            ovf_reg[0]  <= C_W'(in_num) >= (C_W'(in_den) << QUO_W);
            side_reg[0] <= in_side;
        end
    end

    // one quotient bit per stage
    for (genvar k = 1; k <= QUO_W; k++)
    begin : g_bit
        localparam int B = QUO_W - k;
        logic [C_W-1:0]   diff;
        logic             take;
        logic [N_W-1:0]   rem_next;
        logic [QUO_W-1:0] quo_next;

        always_comb
        begin
            diff     = C_W'(rem_reg[k-1]) - (C_W'(den_reg[k-1]) << B);
            take     = !diff[C_W-1];
            rem_next = take ? diff[N_W-1:0] : rem_reg[k-1];
            quo_next = take ? (quo_reg[k-1] | (QUO_W'(1) << B)) : quo_reg[k-1];
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rem_reg[k]  <= rem_next;
                den_reg[k]  <= den_reg[k-1];
                quo_reg[k]  <= quo_next;
                ovf_reg[k]  <= ovf_reg[k-1];
                side_reg[k] <= side_reg[k-1];
            end
        end
    end

    assign out_valid = v_reg[QUO_W];
    assign out_quo   = quo_reg[QUO_W];
    assign out_ovf   = ovf_reg[QUO_W];
    assign out_side  = side_reg[QUO_W];

endmodule

// ===== tb/pairwise_gravity_accel_top_tb.sv =====
// testbench for the pairwise gravity acceleration pipeline
`timescale 1ns / 1ps

// predicts each accepted pair and checks the returned increments in order
class gravity_scoreboard;
    logic [31:0] gain;
    pga_pkg::pga_out_t pending_q[$];
    int errors;

    function new();
        gain = pga_pkg::GAIN_RESET;
        errors = 0;
    endfunction

    // integer square root, bit by bit
    function automatic logic [63:0] root_of(logic [63:0] v);
        logic [63:0] res;
        logic [63:0] bitv;
        res = 0;
        bitv = 64'd1 << 62;
        while (bitv > v) bitv = bitv >> 2;
        while (bitv != 0)
        begin
            if (v >= res + bitv)
            begin
                v = v - (res + bitv);
                res = (res >> 1) + bitv;
            end
            else
                res = res >> 1;
            bitv = bitv >> 2;
        end
        return res;
    endfunction

    // one signed increment with truncation toward zero and saturation
    function automatic logic [31:0] increment(logic [63:0] gm, logic [63:0] mag, bit neg,
                                              logic [127:0] cube, int e);
        logic [127:0] num;
        logic [127:0] q;
        num = ({64'd0, gm} * {64'd0, mag}) << e;
        q = num / cube;
        if (neg)
        begin
            if (q > 128'h8000_0000) q = 128'h8000_0000;
            return 32'(-q[31:0]);
        end
        if (q > 128'h7FFF_FFFF) q = 128'h7FFF_FFFF;
        return q[31:0];
    endfunction

    // note an accepted pair and queue its increments
    function void note(pga_pkg::pga_in_t b);
        pga_pkg::pga_out_t r;
        logic signed [63:0] dx;
        logic signed [63:0] dy;
        logic [63:0] ux;
        logic [63:0] uy;
        logic [63:0] sq;
        logic [63:0] rt;
        logic [127:0] cube;
        logic [63:0] go;
        logic [63:0] gs;
        int sh;
        int e;
        r = '0;
        dx = 64'(b.other_x) - 64'(b.self_x);
        dy = 64'(b.other_y) - 64'(b.self_y);
        ux = dx < 0 ? -dx : dx;
        uy = dy < 0 ? -dy : dy;
        sh = (ux >= 64'h8000_0000 || uy >= 64'h8000_0000) ? 1 : 0;
        ux = ux >> sh;
        uy = uy >> sh;
        sq = ux * ux + uy * uy;
        if (!(sh == 0 && sq <= (64'd1 << 32)))
        begin
            rt = root_of(sq);
            cube = {64'd0, rt} * {64'd0, rt} * {64'd0, rt};
            e = 2 * 16 - 24 - 2 * sh;
            go = {32'd0, gain} * {32'd0, b.other_mass};
            gs = {32'd0, gain} * {32'd0, b.self_mass};
            r.self_ax  = increment(go, ux, dx < 0, cube, e);
            r.self_ay  = increment(go, uy, dy < 0, cube, e);
            r.other_ax = increment(gs, ux, dx < 0, cube, e);
            r.other_ay = increment(gs, uy, dy < 0, cube, e);
            r.applied  = 1'b1;
        end
        pending_q.push_back(r);
    endfunction

    // compare one returned beat with the oldest prediction
    function void check(pga_pkg::pga_out_t a);
        pga_pkg::pga_out_t x;
        if (pending_q.size() == 0)
        begin
            $error("result beat with nothing pending: %h", a);
            errors++;
            return;
        end
        x = pending_q.pop_front();
        if (a.self_ax !== x.self_ax)
        begin
            $error("self_ax expected %0d actual %0d", x.self_ax, a.self_ax);
            errors++;
        end
        if (a.self_ay !== x.self_ay)
        begin
            $error("self_ay expected %0d actual %0d", x.self_ay, a.self_ay);
            errors++;
        end
        if (a.other_ax !== x.other_ax)
        begin
            $error("other_ax expected %0d actual %0d", x.other_ax, a.other_ax);
            errors++;
        end
        if (a.other_ay !== x.other_ay)
        begin
            $error("other_ay expected %0d actual %0d", x.other_ay, a.other_ay);
            errors++;
        end
        if (a.applied !== x.applied)
        begin
            $error("applied expected %0d actual %0d", x.applied, a.applied);
            errors++;
        end
    endfunction
endclass

module pairwise_gravity_accel_top_tb;
    import pga_pkg::*;

    logic clk;
    logic rst_n;
    logic in_valid;
    logic in_ready;
    pga_in_t in_data;
    logic out_valid;
    logic out_ready;
    pga_out_t out_data;
    logic cfg_we;
    logic [GAIN_W-1:0] cfg_wdata;

    gravity_scoreboard sb;
    int stall_mode;
    int burst_left;

    pairwise_gravity_accel_top DUT (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
        .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
        .cfg_we(cfg_we), .cfg_wdata(cfg_wdata)
    );

    // clock
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // run limit
    initial
    begin
        #20ms;
        $display("== FAIL ==");
        $finish;
    end

    // watch both channels
    always @(posedge clk)
    begin
        if (rst_n && in_valid && in_ready) sb.note(in_data);
        if (rst_n && out_valid && out_ready) sb.check(out_data);
    end

    // receiver stall pattern
    always @(posedge clk)
    begin
        case (stall_mode)
            0: out_ready <= 1'b1;
            1: out_ready <= ($urandom_range(0, 9) < 7);
            default: out_ready <= ($urandom_range(0, 15) != 0) ? out_ready
                                                               : ~out_ready;
        endcase
    end

    // send one beat; back to back inside a burst, random gaps between bursts
    task automatic send_pair(pga_in_t b);
        int gap;
        if (burst_left == 0)
        begin
            gap = $urandom_range(0, 6);
            if (gap != 0)
            begin
                in_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            burst_left = $urandom_range(1, 24);
        end
        in_valid <= 1'b1;
        in_data <= b;
        burst_left--;
        do @(posedge clk); while (!in_ready);
    endtask

    task automatic send_pos(logic [31:0] sx, logic [31:0] sy, logic [31:0] ox,
                            logic [31:0] oy, logic [31:0] ms, logic [31:0] mo);
        pga_in_t b;
        b.self_x = sx;
        b.self_y = sy;
        b.other_x = ox;
        b.other_y = oy;
        b.self_mass = ms;
        b.other_mass = mo;
        send_pair(b);
    endtask

    // random pair: mostly near neighbors, some anywhere in range
    task automatic send_random();
        logic [31:0] sx;
        logic [31:0] sy;
        logic [31:0] ms;
        logic [31:0] mo;
        int span;
        sx = $urandom;
        sy = $urandom;
        ms = $urandom_range(0, 3) == 0 ? $urandom | 1 : $urandom_range(1, 32'h0010_0000);
        mo = $urandom_range(0, 3) == 0 ? $urandom | 1 : $urandom_range(1, 32'h0010_0000);
        case ($urandom_range(0, 3))
            0: send_pos(sx, sy, $urandom, $urandom, ms, mo);
            1: send_pos(sx, sy, sx + $urandom_range(0, 4096) - 2048,
                        sy + $urandom_range(0, 4096) - 2048, ms, mo);
            default:
            begin
                span = 1 << $urandom_range(16, 28);
                send_pos(sx, sy, sx + $urandom_range(0, span) - span / 2,
                         sy + $urandom_range(0, span) - span / 2, ms, mo);
            end
        endcase
    endtask

    // write the gain once everything in flight has drained
    task automatic write_gain(logic [31:0] g);
        in_valid <= 1'b0;
        @(posedge clk);
        while (sb.pending_q.size() != 0) @(posedge clk);
        repeat (80) @(posedge clk);
        cfg_we <= 1'b1;
        cfg_wdata <= g;
        @(posedge clk);
        cfg_we <= 1'b0;
        sb.gain = g;
    endtask

    // stimulus
    initial
    begin
        logic [31:0] gains[6];
        sb = new();
        rst_n = 1'b0;
        in_valid = 1'b0;
        in_data = '0;
        out_ready = 1'b0;
        cfg_we = 1'b0;
        cfg_wdata = '0;
        stall_mode = 0;
        burst_left = 0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;

        // directed corners at the reset gain
        send_pos(32'd100, 32'd200, 32'd100, 32'd200, 32'd65536, 32'd65536);
        send_pos(0, 0, 32'h0001_0000, 0, 32'd65536, 32'd65536);
        send_pos(0, 0, 32'h0001_0001, 0, 32'd65536, 32'd65536);
        send_pos(0, 0, 0, 32'hFFFF_0000, 32'd65536, 32'd65536);
        send_pos(0, 0, 0, 32'hFFFE_FFFF, 32'd65536, 32'd65536);
        send_pos(32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_pos(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000, 1, 1);
        send_pos(32'h8000_0000, 0, 32'h7FFF_FFFF, 0, 1, 32'hFFFF_FFFF);
        send_pos(0, 32'h7FFF_FFFF, 0, 32'h8000_0000, 32'hFFFF_FFFF, 1);
        send_pos(0, 0, 32'h0001_8000, 32'hFFFE_8000, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_pos(0, 0, 32'h0000_C000, 32'h0000_C000, 32'd65536, 32'd65536);
        send_pos(0, 0, 32'h0000_B505, 32'h0000_B505, 32'd65536, 32'd65536);
        send_pos(32'h4000_0000, 32'hC000_0000, 32'hC000_0000, 32'h4000_0000,
                 32'h0100_0000, 32'h0000_0001);
        send_pos(32'h1234_5678, 32'hEDCB_A987, 32'h1234_0000, 32'hEDCB_0000,
                 32'h8000_0000, 32'h7FFF_FFFF);

        // phases over several gains and stall patterns
        gains[0] = 32'hFFFF_FFFF;
        gains[1] = 32'd0;
        gains[2] = 32'd1;
        gains[3] = $urandom;
        gains[4] = 32'h0010_0000;
        gains[5] = GAIN_RESET;
        for (int p = 0; p < 6; p++)
        begin
            write_gain(gains[p]);
            stall_mode = p % 3;
            for (int i = 0; i < 290; i++) send_random();
        end

        // drain
        in_valid <= 1'b0;
        @(posedge clk);
        while (sb.pending_q.size() != 0) @(posedge clk);
        repeat (80) @(posedge clk);
        if (sb.errors == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end
endmodule
